// File: rtl/core/cbpa_pkg.sv
// Shared types and constants of the chunked block pool allocator.
`timescale 1ns / 1ps
package cbpa_pkg;

    localparam int HANDLE_W    = 8;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 9;
    localparam int CHUNK_CNT_W = 8;

    localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;

    localparam logic [COUNT_W-1:0]     TOTAL_MAX     = 9'd511;
    localparam logic [CHUNK_CNT_W-1:0] CHUNK_CNT_MAX = 8'd255;

    localparam int RECIP_SHIFT = 16;

    typedef struct packed {
        logic latch;
        logic init_step;
        logic rd_head;
        logic addr_calc;
        logic blk_rd;
        logic alloc_commit;
        logic div_mul;
        logic rd_free;
        logic free_commit;
        logic out_empty;
        logic out_foreign;
    } t_dp_cmd;

    typedef struct packed {
        logic init_last;
        logic head_none;
        logic ff_bad;
        logic foreign;
    } t_dp_sts;

endpackage

// File: rtl/core/chunked_block_pool_allocator_unit.sv
// Top level of the chunked block pool allocator.
//
// A request transfer is taken at a rising edge with i_start high and o_busy low:
// i_req_type selects allocate (0) or free (1), and i_block_handle names the block
// to free. Exactly one result follows each request, shown for a single cycle with
// o_valid high, carrying o_status, o_granted_handle and o_free_count. The receiver
// cannot stall; it must take the result in that cycle.
// An allocate may end with the pool reporting exhaustion on an empty head chunk
// or a broken chunk list, and a free may end on a foreign handle. An allocate
// makes dependent reads of the chunk memory and then the block memory, each with
// a registered read port. A new request may be accepted in the same cycle that
// a result is shown.
// After reset, o_busy stays high while both memories are initialized one block
// entry per cycle.
`timescale 1ns / 1ps
module chunked_block_pool_allocator_unit import cbpa_pkg::*; #(
    parameter int NUM_CHUNKS       = 16,
    parameter int BLOCKS_PER_CHUNK = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic                i_req_type,
    input  logic [HANDLE_W-1:0] i_block_handle,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic [COUNT_W-1:0]  o_free_count
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    cbpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (o_busy)
    );

    cbpa_dp #(
        .NUM_CHUNKS       (NUM_CHUNKS),
        .BLOCKS_PER_CHUNK (BLOCKS_PER_CHUNK)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_block_handle   (i_block_handle),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_granted_handle (o_granted_handle),
        .o_free_count     (o_free_count)
    );

endmodule

// File: rtl/core/cbpa_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module cbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cbpa_dp.sv
// Datapath of the allocator: head and total registers, chunk and block memories, result registers.
`timescale 1ns / 1ps
module cbpa_dp import cbpa_pkg::*; #(
    parameter int NUM_CHUNKS       = 16,
    parameter int BLOCKS_PER_CHUNK = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [HANDLE_W-1:0] i_block_handle,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_granted_handle,
    output logic [COUNT_W-1:0]  o_free_count
);

    localparam int CW    = $clog2(NUM_CHUNKS + 1);
    localparam int CAW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BW    = $clog2(BLOCKS_PER_CHUNK + 1);
    localparam int POOL  = NUM_CHUNKS * BLOCKS_PER_CHUNK;
    localparam int PAW   = (POOL > 1) ? $clog2(POOL) : 1;
    localparam int CWORD = CW + BW + CHUNK_CNT_W;
    localparam int AP_W  = CW + HANDLE_W + 1;
    localparam int DP_W  = HANDLE_W + RECIP_SHIFT + 1;
    localparam int BP_W  = 2 * HANDLE_W;
    localparam int RECIP = ((1 << RECIP_SHIFT) + BLOCKS_PER_CHUNK - 1) / BLOCKS_PER_CHUNK;
    localparam int TOTAL_INIT = (POOL > 511) ? 511 : POOL;

    logic [HANDLE_W-1:0]    r_handle;
    logic [HANDLE_W-1:0]    r_c;
    logic [BW-1:0]          r_b;
    logic [PAW-1:0]         r_addr;
    logic [HANDLE_W-1:0]    r_grant;
    logic [CW-1:0]          r_head;
    logic [CW-1:0]          n_head;
    logic [COUNT_W-1:0]     r_total;
    logic [COUNT_W-1:0]     n_total;
    logic [CAW-1:0]         r_ic;
    logic [BW-1:0]          r_ib;
    logic [PAW-1:0]         r_ia;
    logic                   r_valid;
    logic [STATUS_W-1:0]    r_status;
    logic [HANDLE_W-1:0]    r_granted;
    logic [COUNT_W-1:0]     r_count;

    logic                   ck_we;
    logic [CAW-1:0]         ck_waddr;
    logic [CWORD-1:0]       ck_wdata;
    logic                   ck_re;
    logic [CAW-1:0]         ck_raddr;
    logic [CWORD-1:0]       ck_rdata;
    logic [CW-1:0]          ck_link;
    logic [BW-1:0]          ck_ff;
    logic [CHUNK_CNT_W-1:0] ck_cnt;
    logic [CHUNK_CNT_W-1:0] cnt_dec;
    logic [CHUNK_CNT_W-1:0] cnt_inc;
    logic                   was_full;

    logic                   bl_we;
    logic [PAW-1:0]         bl_waddr;
    logic [BW-1:0]          bl_wdata;
    logic [BW-1:0]          bl_rdata;

    logic [AP_W-1:0]        addr_prod;
    logic [DP_W-1:0]        div_prod;
    logic [BP_W-1:0]        b_prod;
    logic [BP_W-1:0]        b_diff;

    assign ck_link = ck_rdata[CWORD-1 -: CW];
    assign ck_ff   = ck_rdata[BW+CHUNK_CNT_W-1 -: BW];
    assign ck_cnt  = ck_rdata[CHUNK_CNT_W-1:0];

    assign cnt_dec  = (ck_cnt != '0) ? ck_cnt - 1'b1 : ck_cnt;
    assign cnt_inc  = (ck_cnt < CHUNK_CNT_MAX) ? ck_cnt + 1'b1 : ck_cnt;
    assign was_full = (ck_cnt == '0);

    assign addr_prod = AP_W'(r_head) * AP_W'(BLOCKS_PER_CHUNK) + AP_W'(ck_ff);
    assign div_prod  = DP_W'(r_handle) * DP_W'(RECIP);
    assign b_prod    = BP_W'(r_c) * BP_W'(BLOCKS_PER_CHUNK);
    assign b_diff    = BP_W'(r_handle) - b_prod;

    assign o_sts.init_last = (r_ia == PAW'(POOL - 1));
    assign o_sts.head_none = (r_head >= CW'(NUM_CHUNKS));
    assign o_sts.ff_bad    = (ck_ff >= BW'(BLOCKS_PER_CHUNK));
    assign o_sts.foreign   = ({1'b0, r_c} >= (HANDLE_W + 1)'(NUM_CHUNKS));

    always_comb begin
        ck_we    = 1'b0;
        ck_waddr = r_c[CAW-1:0];
        ck_wdata = {ck_link, ck_ff, ck_cnt};
        bl_we    = 1'b0;
        bl_waddr = PAW'(r_handle);
        bl_wdata = ck_ff;
        n_head   = r_head;
        n_total  = r_total;
        if (i_cmd.init_step) begin
            ck_we    = 1'b1;
            ck_waddr = r_ic;
            ck_wdata = {CW'(r_ic) + 1'b1, BW'(0), CHUNK_CNT_W'(BLOCKS_PER_CHUNK)};
            bl_we    = 1'b1;
            bl_waddr = r_ia;
            bl_wdata = r_ib + 1'b1;
        end else if (i_cmd.alloc_commit) begin
            ck_we    = 1'b1;
            ck_waddr = r_head[CAW-1:0];
            ck_wdata = {ck_link, bl_rdata, cnt_dec};
            if (cnt_dec == '0) begin
                n_head = ck_link;
            end
            if (r_total != '0) begin
                n_total = r_total - 1'b1;
            end
        end else if (i_cmd.free_commit) begin
            ck_we    = 1'b1;
            ck_wdata = {was_full ? r_head : ck_link, r_b, cnt_inc};
            bl_we    = 1'b1;
            if (was_full) begin
                n_head = CW'(r_c);
            end
            if (r_total < TOTAL_MAX) begin
                n_total = r_total + 1'b1;
            end
        end
    end

    assign ck_re    = i_cmd.rd_head | i_cmd.rd_free;
    assign ck_raddr = i_cmd.rd_head ? r_head[CAW-1:0] : r_c[CAW-1:0];

    cbpa_ram #(
        .WIDTH (CWORD),
        .DEPTH (NUM_CHUNKS)
    ) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (ck_we),
        .i_waddr (ck_waddr),
        .i_wdata (ck_wdata),
        .i_re    (ck_re),
        .i_raddr (ck_raddr),
        .o_rdata (ck_rdata)
    );

    cbpa_ram #(
        .WIDTH (BW),
        .DEPTH (POOL)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (bl_we),
        .i_waddr (bl_waddr),
        .i_wdata (bl_wdata),
        .i_re    (i_cmd.blk_rd),
        .i_raddr (r_addr),
        .o_rdata (bl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_handle <= i_block_handle;
        end
        if (i_cmd.div_mul) begin
            r_c <= div_prod[RECIP_SHIFT +: HANDLE_W];
        end
        if (i_cmd.rd_free) begin
            r_b <= b_diff[BW-1:0];
        end
        if (i_cmd.addr_calc) begin
            r_addr  <= addr_prod[PAW-1:0];
            r_grant <= addr_prod[HANDLE_W-1:0];
        end
        r_status  <= i_cmd.alloc_commit ? STATUS_ALLOC :
                     (i_cmd.out_empty ? STATUS_EMPTY : STATUS_FREED);
        r_granted <= i_cmd.alloc_commit ? r_grant : '0;
        r_count   <= n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_total <= COUNT_W'(TOTAL_INIT);
            r_ic    <= '0;
            r_ib    <= '0;
            r_ia    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_total <= n_total;
            r_valid <= i_cmd.alloc_commit | i_cmd.free_commit |
                       i_cmd.out_empty | i_cmd.out_foreign;
            if (i_cmd.init_step) begin
                r_ia <= r_ia + 1'b1;
                if (r_ib == BW'(BLOCKS_PER_CHUNK - 1)) begin
                    r_ib <= '0;
                    r_ic <= r_ic + 1'b1;
                end else begin
                    r_ib <= r_ib + 1'b1;
                end
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_granted_handle = r_granted;
    assign o_free_count     = r_count;

`ifndef NO_ASSERTIONS
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= CW'(NUM_CHUNKS))
        else $error("head chunk out of range");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != STATUS_ALLOC) |-> (r_granted == '0))
        else $error("granted handle set on a result without a grant");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_status == STATUS_ALLOC || r_status == STATUS_EMPTY ||
                     r_status == STATUS_FREED))
        else $error("undefined status code on a result");
`endif

endmodule

// File: rtl/core/cbpa_ctrl.sv
// Controller state machine of the allocator: sequences the memory sweep and each request.
`timescale 1ns / 1ps
module cbpa_ctrl import cbpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_req_type,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_A_CHK    = 4'd2;
    localparam logic [3:0] ST_A_ADDR   = 4'd3;
    localparam logic [3:0] ST_A_LINK   = 4'd4;
    localparam logic [3:0] ST_A_COMMIT = 4'd5;
    localparam logic [3:0] ST_F_DIV    = 4'd6;
    localparam logic [3:0] ST_F_RD     = 4'd7;
    localparam logic [3:0] ST_F_COMMIT = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = i_req_type ? ST_F_DIV : ST_A_CHK;
                end
            end
            ST_A_CHK: begin
                if (i_sts.head_none) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = ST_A_ADDR;
                end
            end
            ST_A_ADDR: begin
                if (i_sts.ff_bad) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.addr_calc = 1'b1;
                    n_state         = ST_A_LINK;
                end
            end
            ST_A_LINK: begin
                o_cmd.blk_rd = 1'b1;
                n_state      = ST_A_COMMIT;
            end
            ST_A_COMMIT: begin
                o_cmd.alloc_commit = 1'b1;
                n_state            = ST_IDLE;
            end
            ST_F_DIV: begin
                o_cmd.div_mul = 1'b1;
                n_state       = ST_F_RD;
            end
            ST_F_RD: begin
                if (i_sts.foreign) begin
                    o_cmd.out_foreign = 1'b1;
                    n_state           = ST_IDLE;
                end else begin
                    o_cmd.rd_free = 1'b1;
                    n_state       = ST_F_COMMIT;
                end
            end
            ST_F_COMMIT: begin
                o_cmd.free_commit = 1'b1;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.out_empty, o_cmd.out_foreign, o_cmd.alloc_commit,
                  o_cmd.free_commit}))
        else $error("more than one result issued in a cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_start) |=> (r_state != ST_IDLE))
        else $error("accepted transfer did not start work");

    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.alloc_commit || o_cmd.free_commit || o_cmd.out_empty ||
         o_cmd.out_foreign) |=> !(o_cmd.alloc_commit || o_cmd.free_commit ||
                                  o_cmd.out_empty || o_cmd.out_foreign))
        else $error("results issued in consecutive cycles");
`endif

endmodule

// File: tb/chunked_block_pool_allocator_unit_tb.sv
// Self-checking testbench for the chunked block pool allocator with a built-in pool predictor.
`timescale 1ns / 1ps
module chunked_block_pool_allocator_unit_tb;
    import cbpa_pkg::*;

    localparam int NCHUNK = 16;
    localparam int NBLK = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    typedef struct {
        logic                req;
        logic [HANDLE_W-1:0] handle;
    } pool_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] granted;
        logic [COUNT_W-1:0]  free_count;
    } pool_result_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic                i_req_type = 1'b0;
    logic [HANDLE_W-1:0] i_block_handle = '0;
    logic                o_busy;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_granted_handle;
    logic [COUNT_W-1:0]  o_free_count;

    logic [4:0]         pool_head;
    logic [4:0]         chunk_next [NCHUNK];
    logic [4:0]         chunk_first_free [NCHUNK];
    logic [7:0]         chunk_count [NCHUNK];
    logic [4:0]         block_next [NCHUNK*NBLK];
    logic [COUNT_W-1:0] pool_free;

    pool_request_t       pending_requests [$];
    pool_result_t        expected_results [$];
    logic [HANDLE_W-1:0] live_handles [$];

    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cycles = 0;

    chunked_block_pool_allocator_unit #(
        .NUM_CHUNKS      (NCHUNK),
        .BLOCKS_PER_CHUNK(NBLK)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_req_type      (i_req_type),
        .i_block_handle  (i_block_handle),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_granted_handle(o_granted_handle),
        .o_free_count    (o_free_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic predict_pool(input logic req, input logic [HANDLE_W-1:0] handle,
                                output pool_result_t res);
        int c;
        int b;
        int idx;
        logic was_full;
        res.status = STATUS_FREED;
        res.granted = '0;
        if (req == REQ_ALLOC) begin
            c = pool_head;
            if (c >= NCHUNK || chunk_first_free[c] >= NBLK) begin
                res.status = STATUS_EMPTY;
            end else begin
                b = chunk_first_free[c];
                idx = c * NBLK + b;
                res.status = STATUS_ALLOC;
                res.granted = HANDLE_W'(idx);
                chunk_first_free[c] = block_next[idx];
                if (pool_free > 0) pool_free = pool_free - 1'b1;
                if (chunk_count[c] > 0) chunk_count[c] = chunk_count[c] - 1'b1;
                if (chunk_count[c] == 0) pool_head = chunk_next[c];
            end
        end else begin
            c = handle / NBLK;
            b = handle % NBLK;
            if (c < NCHUNK) begin
                idx = c * NBLK + b;
                was_full = (chunk_count[c] == 0);
                block_next[idx] = chunk_first_free[c];
                chunk_first_free[c] = 5'(b);
                if (chunk_count[c] < CHUNK_CNT_MAX) chunk_count[c] = chunk_count[c] + 1'b1;
                if (pool_free < TOTAL_MAX) pool_free = pool_free + 1'b1;
                if (was_full) begin
                    chunk_next[c] = pool_head;
                    pool_head = 5'(c);
                end
            end
        end
        res.free_count = pool_free;
    endtask

    task automatic queue_request(input logic req, input logic [HANDLE_W-1:0] handle);
        pool_request_t item;
        pool_result_t res;
        item.req = req;
        item.handle = handle;
        predict_pool(req, handle, res);
        pending_requests.push_back(item);
        expected_results.push_back(res);
        if (req == REQ_ALLOC && res.status == STATUS_ALLOC) begin
            live_handles.push_back(res.granted);
        end else if (req == REQ_FREE) begin
            for (int k = 0; k < live_handles.size(); k++) begin
                if (live_handles[k] == handle) begin
                    live_handles.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic queue_wellformed(input int alloc_pct);
        int k;
        if (live_handles.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
            queue_request(REQ_ALLOC, HANDLE_W'($urandom_range(0, 255)));
        end else begin
            k = $urandom_range(0, live_handles.size() - 1);
            queue_request(REQ_FREE, live_handles[k]);
        end
    endtask

    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            taken = i_start && !o_busy;
            if (taken) begin
                void'(pending_requests.pop_front());
                n_accepted <= n_accepted + 1;
            end
            if (!i_start || taken) begin
                if (pending_requests.size() > 0 &&
                    !((n_accepted < 700 || n_accepted >= 1000) &&
                      $urandom_range(0, 99) < 26)) begin
                    i_start <= 1'b1;
                    i_req_type <= pending_requests[0].req;
                    i_block_handle <= pending_requests[0].handle;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        pool_result_t want;
        if (i_rst_n && o_valid) begin
            if (n_checked >= n_accepted || expected_results.size() == 0) begin
                $display("%0t: result with no request outstanding: status %0d handle %0d free %0d",
                         $time, o_status, o_granted_handle, o_free_count);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (o_status !== want.status || o_granted_handle !== want.granted ||
                    o_free_count !== want.free_count) begin
                    $display("%0t: request %0d expected status %0d handle %0d free %0d, actual status %0d handle %0d free %0d",
                             $time, n_checked - 1, want.status, want.granted,
                             want.free_count, o_status, o_granted_handle, o_free_count);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("chunked_block_pool_allocator_unit test failed");
            $finish;
        end
    end

    initial begin
        pool_head = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            chunk_next[c] = 5'(c + 1);
            chunk_first_free[c] = '0;
            chunk_count[c] = 8'(NBLK);
            for (int b = 0; b < NBLK; b++) block_next[c * NBLK + b] = 5'(b + 1);
        end
        pool_free = COUNT_W'(NCHUNK * NBLK);

        queue_request(REQ_ALLOC, 8'h00);
        queue_request(REQ_ALLOC, 8'hFF);
        queue_request(REQ_ALLOC, 8'h55);
        queue_request(REQ_FREE, 8'h01);
        queue_request(REQ_ALLOC, 8'hAA);
        queue_request(REQ_FREE, 8'h00);
        queue_request(REQ_FREE, 8'h02);
        queue_request(REQ_FREE, 8'h01);
        queue_request(REQ_ALLOC, 8'h0F);
        queue_request(REQ_ALLOC, 8'hF0);
        queue_request(REQ_FREE, live_handles[1]);
        queue_request(REQ_FREE, live_handles[0]);

        // Fill the pool past exhaustion, drain it, then run a balanced mix.
        for (int i = 0; i < 800; i++) begin
            queue_wellformed(i < 330 ? 95 : (i < 600 ? 8 : 55));
        end

        // Repeated frees into one chunk and across the pool drive both counters
        // into saturation before the lists are drained again.
        for (int i = 0; i < 250; i++) begin
            queue_request(REQ_FREE, {4'd5, 4'($urandom_range(0, 15))});
        end
        for (int i = 0; i < 300; i++) begin
            queue_request(REQ_FREE, HANDLE_W'($urandom_range(0, 255)));
        end
        for (int i = 0; i < 600; i++) begin
            if ($urandom_range(0, 99) < 90) begin
                queue_request(REQ_ALLOC, HANDLE_W'($urandom_range(0, 255)));
            end else begin
                queue_request(REQ_FREE, HANDLE_W'($urandom_range(0, 255)));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("chunked_block_pool_allocator_unit test passed");
        end else begin
            $display("chunked_block_pool_allocator_unit test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cbpa_pkg.sv
rtl/core/cbpa_ram.sv
rtl/core/cbpa_dp.sv
rtl/core/cbpa_ctrl.sv
rtl/core/chunked_block_pool_allocator_unit.sv
tb/chunked_block_pool_allocator_unit_tb.sv
